>>> rtl/pbld_pkg.sv
package pbld_pkg;

    localparam int SLOTS   = 16;
    localparam int IW      = $clog2(SLOTS);
    localparam int MAX_RES = 16;
    localparam int CW      = $clog2(MAX_RES);
    localparam int FILE_W  = 4;
    localparam int PAGE_W  = 60;
    localparam int TAG_W   = FILE_W + PAGE_W;
    localparam int CNT_W   = 32;
    localparam int FRAME_W = 4;

    typedef enum logic [2:0] {
        REQ_FETCH       = 3'd0,
        REQ_MARK_DIRTY  = 3'd1,
        REQ_FREE        = 3'd2,
        REQ_FLUSH       = 3'd3,
        REQ_FLUSH_EVICT = 3'd4,
        REQ_FLUSH_ALL   = 3'd5,
        REQ_PURGE       = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_APPLY,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic lookup;
        logic apply;
        logic flush_step;
    } t_cmd;

    typedef struct packed {
        logic flush_go;
        logic flush_last;
    } t_status;

endpackage

>>> rtl/pbld_ctrl.sv
module pbld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  pbld_pkg::t_status i_status,
    output pbld_pkg::t_cmd    o_cmd,
    output logic              busy
);

    pbld_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbld_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pbld_pkg::ST_IDLE: begin
                if (start) n_state = pbld_pkg::ST_LOOKUP;
            end
            pbld_pkg::ST_LOOKUP: begin
                n_state = pbld_pkg::ST_APPLY;
            end
            pbld_pkg::ST_APPLY: begin
                if (i_status.flush_go && !i_status.flush_last) n_state = pbld_pkg::ST_FLUSH;
                else n_state = pbld_pkg::ST_IDLE;
            end
            pbld_pkg::ST_FLUSH: begin
                if (i_status.flush_last) n_state = pbld_pkg::ST_IDLE;
            end
            default: begin
                n_state = pbld_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            pbld_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            pbld_pkg::ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            pbld_pkg::ST_APPLY: begin
                // A flush-all with dirty pages sends its first beat straight away.
                o_cmd.apply      = !i_status.flush_go;
                o_cmd.flush_step = i_status.flush_go;
            end
            pbld_pkg::ST_FLUSH: begin
                o_cmd.flush_step = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/pbld_datapath.sv
module pbld_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbld_pkg::t_cmd                i_cmd,
    output pbld_pkg::t_status             o_status,
    input  logic [2:0]                    i_req_type,
    input  logic [pbld_pkg::FILE_W-1:0]   i_file_id,
    input  logic [pbld_pkg::PAGE_W-1:0]   i_raw_page,
    output logic                          o_result_valid,
    output logic [pbld_pkg::FRAME_W-1:0]  o_frame,
    output logic                          o_hit,
    output logic                          o_load_request,
    output logic                          o_writeback_valid,
    output logic [pbld_pkg::FILE_W-1:0]   o_writeback_file,
    output logic [pbld_pkg::PAGE_W-1:0]   o_writeback_page,
    output logic                          o_release_request,
    output logic                          o_last,
    output logic [pbld_pkg::CNT_W-1:0]    o_logical_count,
    output logic [pbld_pkg::CNT_W-1:0]    o_physical_count
);

    localparam int S  = pbld_pkg::SLOTS;
    localparam int IW = pbld_pkg::IW;

    logic [pbld_pkg::TAG_W-1:0] r_tag [S];
    logic [S-1:0]               r_used;
    logic [S-1:0]               r_dirty;
    logic [IW-1:0]              r_rank [S];
    logic [pbld_pkg::CNT_W-1:0] r_lcnt, r_pcnt;

    logic [2:0]                 r_req;
    logic [pbld_pkg::TAG_W-1:0] r_key;
    logic                       r_hit, r_free_ok;
    logic [IW-1:0]              r_hidx, r_free_idx, r_victim;
    logic [pbld_pkg::CW-1:0]    r_fcnt;

    // Lookup stage: parallel compare, lowest free frame and the oldest frame.
    logic          l_hit, l_free_ok;
    logic [IW-1:0] l_hidx, l_free_idx, l_victim;

    always_comb begin
        l_hit      = 1'b0;
        l_free_ok  = 1'b0;
        l_hidx     = '0;
        l_free_idx = '0;
        l_victim   = '0;
        for (int i = S - 1; i >= 0; i--) begin
            if (r_used[i] && r_tag[i] == r_key) begin
                l_hit  = 1'b1;
                l_hidx = IW'(i);
            end
            if (!r_used[i]) begin
                l_free_ok  = 1'b1;
                l_free_idx = IW'(i);
            end
            if (r_used[i] && r_rank[i] == IW'(S - 1)) l_victim = IW'(i);
        end
    end

    // Flush-all: lowest dirty frame and whether any remain after it or the beat limit is reached.
    logic [S-1:0]  f_vec, f_rest;
    logic [IW-1:0] f_idx;

    always_comb begin
        f_vec = r_used & r_dirty;
        f_idx = '0;
        for (int i = S - 1; i >= 0; i--) begin
            if (f_vec[i]) f_idx = IW'(i);
        end
        f_rest = f_vec & ~(S'(1) << f_idx);
        o_status.flush_go   = (r_req == pbld_pkg::REQ_FLUSH_ALL) && (f_vec != '0);
        o_status.flush_last = (f_rest == '0) || (r_fcnt == pbld_pkg::CW'(pbld_pkg::MAX_RES - 1));
    end

    logic [pbld_pkg::CNT_W-1:0] lcnt_inc, pcnt_inc;
    logic [IW-1:0]              hrank, fill;
    logic                       hdirty;

    always_comb begin
        lcnt_inc = (r_lcnt == '1) ? r_lcnt : r_lcnt + 1'b1;
        pcnt_inc = (r_pcnt == '1) ? r_pcnt : r_pcnt + 1'b1;
        hrank    = r_rank[r_hidx];
        hdirty   = r_dirty[r_hidx];
        fill     = r_free_ok ? r_free_idx : r_victim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used         <= '0;
            r_dirty        <= '0;
            r_lcnt         <= '0;
            r_pcnt         <= '0;
            r_req          <= '0;
            r_fcnt         <= '0;
            o_result_valid <= 1'b0;
            for (int i = 0; i < S; i++) r_rank[i] <= '0;
        end else begin
            o_result_valid <= i_cmd.apply || i_cmd.flush_step;

            if (i_cmd.load) begin
                r_req  <= i_req_type;
                r_key  <= {i_file_id, i_raw_page};
                r_fcnt <= '0;
            end

            if (i_cmd.lookup) begin
                r_hit      <= l_hit;
                r_hidx     <= l_hidx;
                r_free_ok  <= l_free_ok;
                r_free_idx <= l_free_idx;
                r_victim   <= l_victim;
            end

            if (i_cmd.apply) begin
                o_frame           <= '0;
                o_hit             <= 1'b0;
                o_load_request    <= 1'b0;
                o_writeback_valid <= 1'b0;
                o_writeback_file  <= '0;
                o_writeback_page  <= '0;
                o_release_request <= 1'b0;
                o_last            <= 1'b1;
                o_logical_count   <= r_lcnt;
                o_physical_count  <= r_pcnt;
                case (r_req)
                    pbld_pkg::REQ_FETCH: begin
                        r_lcnt          <= lcnt_inc;
                        o_logical_count <= lcnt_inc;
                        if (r_hit) begin
                            for (int i = 0; i < S; i++) begin
                                if (r_used[i] && r_rank[i] < hrank) r_rank[i] <= r_rank[i] + 1'b1;
                            end
                            r_rank[r_hidx] <= '0;
                            o_hit          <= 1'b1;
                            o_frame        <= pbld_pkg::FRAME_W'(r_hidx);
                        end else begin
                            // With every frame full the oldest frame is reused.
                            if (!r_free_ok && r_dirty[r_victim]) begin
                                o_writeback_valid <= 1'b1;
                                o_writeback_file  <= r_tag[r_victim][pbld_pkg::TAG_W-1 -: pbld_pkg::FILE_W];
                                o_writeback_page  <= r_tag[r_victim][pbld_pkg::PAGE_W-1:0];
                            end
                            for (int i = 0; i < S; i++) begin
                                if (r_used[i]) r_rank[i] <= r_rank[i] + 1'b1;
                            end
                            r_rank[fill]     <= '0;
                            r_used[fill]     <= 1'b1;
                            r_dirty[fill]    <= 1'b0;
                            r_tag[fill]      <= r_key;
                            r_pcnt           <= pcnt_inc;
                            o_physical_count <= pcnt_inc;
                            o_load_request   <= 1'b1;
                            o_frame          <= pbld_pkg::FRAME_W'(fill);
                        end
                    end
                    pbld_pkg::REQ_MARK_DIRTY: begin
                        if (r_hit) r_dirty[r_hidx] <= 1'b1;
                    end
                    pbld_pkg::REQ_FREE, pbld_pkg::REQ_FLUSH, pbld_pkg::REQ_FLUSH_EVICT: begin
                        if (r_hit) begin
                            if (r_req != pbld_pkg::REQ_FREE && hdirty) begin
                                o_writeback_valid <= 1'b1;
                                o_writeback_file  <= r_key[pbld_pkg::TAG_W-1 -: pbld_pkg::FILE_W];
                                o_writeback_page  <= r_key[pbld_pkg::PAGE_W-1:0];
                            end
                            r_dirty[r_hidx] <= 1'b0;
                            if (r_req != pbld_pkg::REQ_FLUSH) begin
                                r_used[r_hidx] <= 1'b0;
                                for (int i = 0; i < S; i++) begin
                                    if (r_used[i] && r_rank[i] > hrank) r_rank[i] <= r_rank[i] - 1'b1;
                                end
                                r_rank[r_hidx] <= '0;
                            end
                            o_release_request <= (r_req == pbld_pkg::REQ_FREE);
                        end
                    end
                    pbld_pkg::REQ_PURGE: begin
                        r_used  <= '0;
                        r_dirty <= '0;
                        for (int i = 0; i < S; i++) r_rank[i] <= '0;
                    end
                    default: begin
                        o_last <= 1'b1;
                    end
                endcase
            end

            if (i_cmd.flush_step) begin
                r_dirty[f_idx]    <= 1'b0;
                r_fcnt            <= r_fcnt + 1'b1;
                o_frame           <= '0;
                o_hit             <= 1'b0;
                o_load_request    <= 1'b0;
                o_writeback_valid <= 1'b1;
                o_writeback_file  <= r_tag[f_idx][pbld_pkg::TAG_W-1 -: pbld_pkg::FILE_W];
                o_writeback_page  <= r_tag[f_idx][pbld_pkg::PAGE_W-1:0];
                o_release_request <= 1'b0;
                o_last            <= o_status.flush_last;
                o_logical_count   <= r_lcnt;
                o_physical_count  <= r_pcnt;
            end
        end
    end

endmodule

>>> rtl/page_buffer_lru_directory.sv
// Page buffer directory with least-recently-used replacement.
// A request (i_req_type, i_file_id, i_raw_page) is taken at a rising edge where
// start is high and busy is low. Results leave on the o_ ports, each shown for
// exactly one cycle while o_result_valid is high; o_last marks the final beat.
// The receiver cannot hold results off, and nothing here waits for it.
// Timing: a request is accepted, compared against all frames in the next cycle,
// applied in the cycle after, and its first result beat is registered out of
// that apply step. A new request may be accepted in the cycle a single-result
// request shows its result.
// Flush-all emits one beat per dirty page on consecutive cycles, or a single
// beat with no write-back if no page is dirty; the sequencer steps through the
// dirty frames, one per cycle.
// A synchronous active-low reset empties the directory, clears the read
// counters and drops any result in flight. Page tags are not cleared; a frame
// is only ever compared while it is marked in use.
module page_buffer_lru_directory (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_req_type,
    input  logic [pbld_pkg::FILE_W-1:0]   i_file_id,
    input  logic [pbld_pkg::PAGE_W-1:0]   i_raw_page,
    output logic                          o_result_valid,
    output logic [pbld_pkg::FRAME_W-1:0]  o_frame,
    output logic                          o_hit,
    output logic                          o_load_request,
    output logic                          o_writeback_valid,
    output logic [pbld_pkg::FILE_W-1:0]   o_writeback_file,
    output logic [pbld_pkg::PAGE_W-1:0]   o_writeback_page,
    output logic                          o_release_request,
    output logic                          o_last,
    output logic [pbld_pkg::CNT_W-1:0]    o_logical_count,
    output logic [pbld_pkg::CNT_W-1:0]    o_physical_count
);

    pbld_pkg::t_cmd    cmd;
    pbld_pkg::t_status status;

    pbld_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    pbld_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_req_type        (i_req_type),
        .i_file_id         (i_file_id),
        .i_raw_page        (i_raw_page),
        .o_result_valid    (o_result_valid),
        .o_frame           (o_frame),
        .o_hit             (o_hit),
        .o_load_request    (o_load_request),
        .o_writeback_valid (o_writeback_valid),
        .o_writeback_file  (o_writeback_file),
        .o_writeback_page  (o_writeback_page),
        .o_release_request (o_release_request),
        .o_last            (o_last),
        .o_logical_count   (o_logical_count),
        .o_physical_count  (o_physical_count)
    );

endmodule

>>> rtl/pbld_checker.sv
module pbld_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_result_valid,
    input logic                          o_hit,
    input logic                          o_load_request,
    input logic                          o_writeback_valid,
    input logic [pbld_pkg::FILE_W-1:0]   o_writeback_file,
    input logic [pbld_pkg::PAGE_W-1:0]   o_writeback_page,
    input logic                          o_last
);

    // A flush-all stream has no gaps between its beats.
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |=> o_result_valid)
        else $error("result stream broken before its last beat");

    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |=> !o_result_valid)
        else $error("result beat follows a last beat too soon");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_result_valid)
        else $error("result shown in the cycle after acceptance");

    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_writeback_valid |->
            o_writeback_file == '0 && o_writeback_page == '0)
        else $error("write-back tag not zero without a write-back");

    a_hit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_hit |-> !o_load_request)
        else $error("hit and load request together");

endmodule

bind page_buffer_lru_directory pbld_checker u_pbld_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_result_valid    (o_result_valid),
    .o_hit             (o_hit),
    .o_load_request    (o_load_request),
    .o_writeback_valid (o_writeback_valid),
    .o_writeback_file  (o_writeback_file),
    .o_writeback_page  (o_writeback_page),
    .o_last            (o_last)
);
